### src/bpf_pkg.sv
// Shared constants, types and codes of the background pixel fetcher.
package bpf_pkg;

  localparam int LINE_WIDTH = 160;
  localparam int FIFO_DEPTH = 16;
  localparam int ROW_PIXELS = 8;
  localparam int COLOR_W    = 32;
  localparam int VRAM_DEPTH = 8192;
  localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int EMIT_W     = $clog2(LINE_WIDTH + 1);

  // push is allowed while the FIFO holds at most one row, pop while it holds more
  localparam logic [FIFO_CNT_W-1:0] ROW_COUNT = FIFO_CNT_W'(ROW_PIXELS);

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_LINE  = 2'd2;

  localparam logic [2:0] REG_LCDC   = 3'd0;
  localparam logic [2:0] REG_SCX    = 3'd1;
  localparam logic [2:0] REG_SCY    = 3'd2;
  localparam logic [2:0] REG_SHADE0 = 3'd3;
  localparam logic [2:0] REG_SHADE1 = 3'd4;
  localparam logic [2:0] REG_SHADE2 = 3'd5;
  localparam logic [2:0] REG_SHADE3 = 3'd6;

  localparam int LCDC_BG_EN   = 0;
  localparam int LCDC_MAP_HI  = 3;
  localparam int LCDC_DATA_LO = 4;

  localparam logic [VRAM_AW-1:0] DATA_AREA_HI = VRAM_AW'(13'h0800);

  typedef enum logic [4:0] {
    STEP_MAP  = 5'b00001,
    STEP_LOW  = 5'b00010,
    STEP_HIGH = 5'b00100,
    STEP_IDLE = 5'b01000,
    STEP_PUSH = 5'b10000
  } step_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef logic [ROW_PIXELS-1:0][COLOR_W-1:0] color_row_t;

endpackage

### src/bpf_fifo.sv
// Colour FIFO: appends a tile row of eight colours at once, pops one colour at the head.
module bpf_fifo
  import bpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  fifo_ctl_t             ctl,
  input  color_row_t            row,
  output logic [FIFO_CNT_W-1:0] count,
  output logic [COLOR_W-1:0]    head_color
);

  localparam int SUM_W = FIFO_CNT_W + 1;

  logic [COLOR_W-1:0]    entries [FIFO_DEPTH];
  logic [FIFO_IDX_W-1:0] head;
  logic [FIFO_IDX_W-1:0] tail;
  logic [FIFO_IDX_W-1:0] head_next;
  logic [FIFO_CNT_W-1:0] count_next;
  logic [FIFO_IDX_W-1:0] slot [ROW_PIXELS];

  function automatic logic [FIFO_IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    begin
      r = (v >= SUM_W'(FIFO_DEPTH)) ? v - SUM_W'(FIFO_DEPTH) : v;
      return r[FIFO_IDX_W-1:0];
    end
  endfunction

  assign head_color = entries[head];
  assign tail       = wrap_idx(SUM_W'(head) + SUM_W'(count));
  assign head_next  = wrap_idx(SUM_W'(head) + SUM_W'(1));

  always_comb begin
    for (int i = 0; i < ROW_PIXELS; i++) begin
      slot[i] = wrap_idx(SUM_W'(tail) + SUM_W'(i));
    end
    count_next = count;
    if (ctl.push) count_next = count_next + ROW_COUNT;
    if (ctl.pop) count_next = count_next - FIFO_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.clear) begin
      head  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (ctl.pop) head <= head_next;
    end
  end

  // caller only pushes with at most one row held, so the row always fits
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear) begin
      for (int i = 0; i < ROW_PIXELS; i++) begin
        entries[slot[i]] <= row[i];
      end
    end
  end

endmodule

### src/background_pixel_fetcher_fifo_unit.sv
// Background tile fetcher and pixel FIFO top level with video memory and register port.
//
// Takes one word per clock: dot ticks, video memory writes and line starts, and
// returns one result word for each. The video memory is a single-port 8 KiB RAM with a
// registered read port; each word makes at most one access to it, and a tile
// number read on one word is forwarded straight into the plane address of the next,
// so back-to-back words never wait on it. The colour FIFO and all fetch bookkeeping
// live in registers. Throughput is one word per clock and each result is registered;
// input stalls only while a finished result is held by output stall.
module background_pixel_fetcher_fifo_unit
  import bpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [7:0]            line,
  input  logic [8:0]            line_tick,
  input  logic [VRAM_AW-1:0]    vram_offset,
  input  logic [7:0]            vram_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  pixel_valid,
  output logic [7:0]            pixel_x,
  output logic [7:0]            pixel_y,
  output logic [COLOR_W-1:0]    pixel_color,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef struct packed {
    logic map;
    logic low;
    logic high;
    logic adj;
  } rd_pend_t;

  // configuration
  logic [7:0]         lcd_control;
  logic [7:0]         scroll_horizontal;
  logic [7:0]         scroll_vertical;
  logic [COLOR_W-1:0] shade [4];
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  // video memory
  logic [7:0]         vram [VRAM_DEPTH];
  logic [7:0]         rdata;
  logic               mem_we;
  logic               mem_re;
  logic [VRAM_AW-1:0] mem_addr;
  logic [VRAM_AW-1:0] map_addr;
  logic [VRAM_AW-1:0] data_addr;
  rd_pend_t           pend;
  rd_pend_t           pend_next;

  // fetch state
  step_t              fetch_step;
  logic [8:0]         fetch_column;
  logic [7:0]         tile_number;
  logic [7:0]         plane_low;
  logic [7:0]         plane_high;
  logic [8:0]         discard_column;
  logic [EMIT_W-1:0]  emit_column;

  logic               acc;
  logic               is_tick;
  logic               adv;
  logic               line_start;
  logic [7:0]         map_x;
  logic [7:0]         map_y;
  logic [7:0]         tile_cur;
  logic [7:0]         rdata_tile;
  logic               push_ok;
  logic               push_en;
  logic [FIFO_CNT_W-1:0] cnt_after;
  logic               pop;
  logic               emit_ok;

  fifo_ctl_t             fctl;
  color_row_t            row;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [COLOR_W-1:0]    head_color;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control       <= '0;
      scroll_horizontal <= '0;
      scroll_vertical   <= '0;
      for (int i = 0; i < 4; i++) shade[i] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LCDC:   lcd_control       <= pwdata[7:0];
        REG_SCX:    scroll_horizontal <= pwdata[7:0];
        REG_SCY:    scroll_vertical   <= pwdata[7:0];
        REG_SHADE0: shade[0]          <= pwdata;
        REG_SHADE1: shade[1]          <= pwdata;
        REG_SHADE2: shade[2]          <= pwdata;
        REG_SHADE3: shade[3]          <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LCDC:   prdata = {24'd0, lcd_control};
      REG_SCX:    prdata = {24'd0, scroll_horizontal};
      REG_SCY:    prdata = {24'd0, scroll_vertical};
      REG_SHADE0: prdata = shade[0];
      REG_SHADE1: prdata = shade[1];
      REG_SHADE2: prdata = shade[2];
      REG_SHADE3: prdata = shade[3];
      default:    prdata = '0;
    endcase
  end

  // ---------------- accept and decode ----------------
  assign in_stall   = out_valid && out_stall;
  assign acc        = in_valid && !in_stall;
  assign is_tick    = acc && (action == ACT_TICK);
  assign adv        = is_tick && !line_tick[0];
  assign line_start = acc && (action == ACT_LINE);

  assign map_y = line + scroll_vertical;
  assign map_x = fetch_column[7:0] + scroll_horizontal;

  // tile number read by the previous word is forwarded from the RAM output
  assign rdata_tile = pend.adj ? rdata + 8'd128 : rdata;
  assign tile_cur   = pend.map ? rdata_tile : tile_number;

  assign map_addr  = {2'b11, lcd_control[LCDC_MAP_HI], map_y[7:3], map_x[7:3]};
  assign data_addr = VRAM_AW'({tile_cur, map_y[2:0], fetch_step == STEP_HIGH})
                   + (lcd_control[LCDC_DATA_LO] ? '0 : DATA_AREA_HI);

  always_comb begin
    mem_we    = acc && (action == ACT_WRITE);
    mem_re    = 1'b0;
    mem_addr  = vram_offset;
    pend_next = '0;
    pend_next.adj = !lcd_control[LCDC_DATA_LO];
    if (adv) begin
      case (fetch_step)
        STEP_MAP: begin
          mem_re        = lcd_control[LCDC_BG_EN];
          mem_addr      = map_addr;
          pend_next.map = lcd_control[LCDC_BG_EN];
        end
        STEP_LOW: begin
          mem_re        = 1'b1;
          mem_addr      = data_addr;
          pend_next.low = 1'b1;
        end
        STEP_HIGH: begin
          mem_re         = 1'b1;
          mem_addr       = data_addr;
          pend_next.high = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vram[mem_addr] <= vram_byte;
    end else if (mem_re) begin
      rdata <= vram[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= '0;
      tile_number <= '0;
      plane_low   <= '0;
      plane_high  <= '0;
    end else begin
      pend <= pend_next;
      if (pend.map)  tile_number <= rdata_tile;
      if (pend.low)  plane_low   <= rdata;
      if (pend.high) plane_high  <= rdata;
    end
  end

  // ---------------- fetch sequencer and FIFO control ----------------
  assign push_ok = adv && (fetch_step == STEP_PUSH) && (fifo_count <= ROW_COUNT);
  // row is dropped when its first pixel column would be negative
  assign push_en = push_ok &&
                   ((10'(fetch_column) + 10'(scroll_horizontal[2:0])) >= 10'(ROW_PIXELS));
  assign cnt_after = push_en ? fifo_count + ROW_COUNT : fifo_count;
  assign pop       = is_tick && (cnt_after > ROW_COUNT);
  assign emit_ok   = pop && (discard_column >= 9'(scroll_horizontal[2:0])) &&
                     (emit_column < EMIT_W'(LINE_WIDTH));

  always_comb begin
    fctl.clear = line_start;
    fctl.push  = push_en;
    fctl.pop   = pop;
    for (int i = 0; i < ROW_PIXELS; i++) begin
      row[i] = shade[{plane_high[ROW_PIXELS-1-i], plane_low[ROW_PIXELS-1-i]}];
    end
  end

  bpf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .ctl        (fctl),
    .row        (row),
    .count      (fifo_count),
    .head_color (head_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_step     <= STEP_MAP;
      fetch_column   <= '0;
      discard_column <= '0;
      emit_column    <= '0;
    end else if (line_start) begin
      fetch_step     <= STEP_MAP;
      fetch_column   <= '0;
      discard_column <= '0;
      emit_column    <= '0;
    end else begin
      if (adv) begin
        case (fetch_step)
          STEP_MAP: begin
            fetch_column <= fetch_column + 9'd8;
            fetch_step   <= STEP_LOW;
          end
          STEP_LOW:  fetch_step <= STEP_HIGH;
          STEP_HIGH: fetch_step <= STEP_IDLE;
          STEP_IDLE: fetch_step <= STEP_PUSH;
          STEP_PUSH: if (push_ok) fetch_step <= STEP_MAP;
          default:   fetch_step <= STEP_MAP;
        endcase
      end
      if (pop) discard_column <= discard_column + 9'd1;
      if (emit_ok) emit_column <= emit_column + EMIT_W'(1);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pixel_valid <= emit_ok;
      pixel_x     <= emit_ok ? 8'(emit_column) : 8'd0;
      pixel_y     <= emit_ok ? line : 8'd0;
      pixel_color <= emit_ok ? head_color : '0;
    end
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word produced no result");

  a_x_in_line: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel_valid) |-> ({1'b0, pixel_x} < 9'(LINE_WIDTH)))
    else $error("pixel emitted beyond line width");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pixel_valid) |->
      (pixel_x == 8'd0 && pixel_y == 8'd0 && pixel_color == '0))
    else $error("non-pixel result carries data");

  a_one_pending: assert property (@(posedge clk) disable iff (rst)
    $onehot0({pend.map, pend.low, pend.high}))
    else $error("more than one video memory read in flight");

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("colour FIFO overfilled");
`endif

endmodule
